/* design/vcos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcos_pkg
// Types, register codes and step functions of the contact occlusion shader.
// ----------------------------------------------------------------------------
package vcos_pkg;

    // register indexes of the configuration channel
    localparam logic [2:0] CFG_CONTACT_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_CONTACT_SPAN   = 3'd1;
    localparam logic [2:0] CFG_LEDGE_FRACTION = 3'd2;
    localparam logic [2:0] CFG_LEDGE_FACTOR   = 3'd3;
    localparam logic [2:0] CFG_FLAT_EPSILON   = 3'd4;

    localparam logic [15:0] RST_CONTACT_FLOOR  = 16'd55050;
    localparam logic [15:0] RST_CONTACT_SPAN   = 16'd10486;
    localparam logic [15:0] RST_LEDGE_FRACTION = 16'd44564;
    localparam logic [15:0] RST_LEDGE_FACTOR   = 16'd62259;
    localparam logic [14:0] RST_FLAT_EPSILON   = 15'd13;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [18:0] SAT_LIMIT = 19'd130560;  // 256 * 510

    typedef struct packed {
        logic       en;
        logic [7:0] bright;
        logic       sloped;
        logic       ledge;
    } ctl_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [3:0][15:0] bo;
        logic [3:0]       full;
        logic [15:0]      rng;
        logic [3:0][15:0] rem;
        logic [3:0][15:0] quo;
    } dv_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [3:0][15:0] bo;
        logic [3:0]       full;
        logic [3:0][31:0] v;
        logic [3:0][31:0] res;
    } sq_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [3:0][15:0] bo;
        logic [3:0][16:0] f;
    } fp_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [3:0][32:0] p;
    } pp_t;

    // four restoring steps of rem * 2^16 / dvs, rem below dvs
    function automatic logic [31:0] div_bits4(input logic [15:0] rem_in,
                                              input logic [15:0] quo_in,
                                              input logic [15:0] dvs);
        logic [16:0] r;
        logic [15:0] q;
        r = {1'b0, rem_in};
        q = quo_in;
        for (int i = 0; i < 4; i++) begin
            r = {r[15:0], 1'b0};
            q = {q[14:0], 1'b0};
            if (r >= {1'b0, dvs}) begin
                r    = r - {1'b0, dvs};
                q[0] = 1'b1;
            end
        end
        return {r[15:0], q};
    endfunction

    // four digit steps of the integer square root, starting at step first
    function automatic logic [63:0] sqrt_bits4(input logic [31:0] v_in,
                                               input logic [31:0] res_in,
                                               input int first);
        logic [32:0] v;
        logic [32:0] res;
        logic [32:0] bitv;
        logic [32:0] trial;
        v   = {1'b0, v_in};
        res = {1'b0, res_in};
        for (int k = 0; k < 4; k++) begin
            bitv  = 33'd1 << (30 - 2 * (first + k));
            trial = res + bitv;
            if (v >= trial) begin
                v   = v - trial;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return {v[31:0], res[31:0]};
    endfunction

    // quotient by 510 for values below 256 * 510: halve, then divide by 255
    // as (x + x / 256 + 1) / 256, exact for quotients up to 255
    function automatic logic [7:0] div510(input logic [16:0] y);
        logic [15:0] x;
        logic [15:0] t;
        x = y[16:1];
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

endpackage

/* design/vertex_contact_occlusion_shader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_contact_occlusion_shader
// Per-vertex contact occlusion brightness for one quad face per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one face per word: four vertex heights, the model height
//   bounds, four occlusion bytes and the face brightness in s_tdata, the
//   shading enable in s_tuser. m_* returns the four shaded brightnesses.
//   cfg_* writes the five shading registers; write only while the block
//   holds no face.
// One face is taken every cycle while the receiver keeps up; the pipeline
// runs a 16-bit normalize divide in four stages of four quotient bits and
// a square root in four stages of four root bits, then the factor
// multiply, the occlusion multiply and the final scale by 1/510 with
// saturation.
// A stalled receiver holds the output word; earlier stages keep filling
// their empty slots, so s_tready drops only once every stage is full.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module vertex_contact_occlusion_shader (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_z0, vertex_z1, vertex_z2, vertex_z3, model_min_z, model_max_z,
    // occlusion0..occlusion3, face_brightness
    input  logic [135:0] s_tdata,
    // ao_enable
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // brightness0, brightness1, brightness2, brightness3
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int NST = 13;

    logic [15:0] floor_reg, span_reg, lfrac_reg, lfac_reg;
    logic [14:0] eps_reg;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    // stage 0
    logic                   s0_en_reg;
    logic [7:0]             s0_b_reg;
    logic [3:0][7:0]        s0_occ_reg;
    logic signed [3:0][16:0] s0_h_reg;
    logic signed [16:0]     s0_range_reg, s0_span_reg;
    logic signed [15:0]     s0_fmax_reg, s0_mx_reg;

    logic signed [15:0]     z [4];
    logic signed [15:0]     mn, mx, fmin, fmax;
    logic [3:0][7:0]        occ;
    logic signed [3:0][16:0] h_next;

    vcos_pkg::dv_t dv_reg  [0:4];
    vcos_pkg::dv_t dv_next [0:4];
    vcos_pkg::sq_t sq_reg  [0:3];
    vcos_pkg::sq_t sq_next [0:3];
    vcos_pkg::fp_t f_reg, f_next;
    vcos_pkg::pp_t p_reg, p_next;
    logic [3:0][7:0] out_reg, out_next;

    logic signed [32:0] ledge_lhs, ledge_rhs;
    logic               rng_ok;

    assign cfg_ready = 1'b1;
    assign s_tready  = rdy[0];
    assign m_tvalid  = vld_reg[NST-1];
    assign m_tdata   = out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= vcos_pkg::RST_CONTACT_FLOOR;
            span_reg  <= vcos_pkg::RST_CONTACT_SPAN;
            lfrac_reg <= vcos_pkg::RST_LEDGE_FRACTION;
            lfac_reg  <= vcos_pkg::RST_LEDGE_FACTOR;
            eps_reg   <= vcos_pkg::RST_FLAT_EPSILON;
        end else if (cfg_valid) begin
            case (cfg_index)
                vcos_pkg::CFG_CONTACT_FLOOR:  floor_reg <= cfg_data;
                vcos_pkg::CFG_CONTACT_SPAN:   span_reg  <= cfg_data;
                vcos_pkg::CFG_LEDGE_FRACTION: lfrac_reg <= cfg_data;
                vcos_pkg::CFG_LEDGE_FACTOR:   lfac_reg  <= cfg_data;
                vcos_pkg::CFG_FLAT_EPSILON:   eps_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its word moves on
    always_comb begin
        rdy[NST] = m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: face bounds and heights above the model floor
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            z[i]   = s_tdata[16*i +: 16];
            occ[i] = s_tdata[96 + 8*i +: 8];
        end
        mn   = s_tdata[79:64];
        mx   = s_tdata[95:80];
        fmin = z[0];
        fmax = z[0];
        for (int i = 1; i < 4; i++) begin
            if (z[i] < fmin) begin
                fmin = z[i];
            end
            if (z[i] > fmax) begin
                fmax = z[i];
            end
        end
        for (int i = 0; i < 4; i++) begin
            h_next[i] = {z[i][15], z[i]} - {mn[15], mn};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_en_reg    <= s_tuser;
            s0_b_reg     <= s_tdata[135:128];
            s0_occ_reg   <= occ;
            s0_h_reg     <= h_next;
            s0_range_reg <= {mx[15], mx} - {mn[15], mn};
            s0_span_reg  <= {fmax[15], fmax} - {fmin[15], fmin};
            s0_fmax_reg  <= fmax;
            s0_mx_reg    <= mx;
        end
    end

    always_comb begin
        // stage 1: classify the face, clamp numerators, occlusion products
        ledge_lhs = {s0_fmax_reg[15], s0_fmax_reg, 16'd0};
        ledge_rhs = s0_mx_reg * $signed({1'b0, lfrac_reg});
        rng_ok    = s0_range_reg > $signed({2'b00, eps_reg});
        dv_next[0].ctl.en     = s0_en_reg;
        dv_next[0].ctl.bright = s0_b_reg;
        dv_next[0].ctl.sloped = s0_span_reg > $signed({2'b00, eps_reg});
        dv_next[0].ctl.ledge  = ledge_lhs < ledge_rhs;
        dv_next[0].rng        = s0_range_reg[15:0];
        dv_next[0].quo        = '0;
        for (int i = 0; i < 4; i++) begin
            dv_next[0].bo[i]   = s0_b_reg * s0_occ_reg[i];
            dv_next[0].full[i] = !rng_ok || ($signed(s0_h_reg[i]) >= s0_range_reg);
            dv_next[0].rem[i]  = ($signed(s0_h_reg[i]) <= 17'sd0) ? 16'd0 :
                                 s0_h_reg[i][15:0];
        end
        // stages 2..5: normalize divide, four quotient bits per stage
        for (int j = 1; j < 5; j++) begin
            dv_next[j] = dv_reg[j-1];
            for (int i = 0; i < 4; i++) begin
                {dv_next[j].rem[i], dv_next[j].quo[i]} =
                    vcos_pkg::div_bits4(dv_reg[j-1].rem[i], dv_reg[j-1].quo[i],
                                        dv_reg[j-1].rng);
            end
        end
    end

    // stages 6..9: square root, four root bits per stage
    always_comb begin
        sq_next[0].ctl  = dv_reg[4].ctl;
        sq_next[0].bo   = dv_reg[4].bo;
        sq_next[0].full = dv_reg[4].full;
        for (int i = 0; i < 4; i++) begin
            {sq_next[0].v[i], sq_next[0].res[i]} =
                vcos_pkg::sqrt_bits4({dv_reg[4].quo[i], 16'd0}, 32'd0, 0);
        end
        for (int j = 1; j < 4; j++) begin
            sq_next[j] = sq_reg[j-1];
            for (int i = 0; i < 4; i++) begin
                {sq_next[j].v[i], sq_next[j].res[i]} =
                    vcos_pkg::sqrt_bits4(sq_reg[j-1].v[i], sq_reg[j-1].res[i], 4 * j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 5; j++) begin
            if (rdy[1+j]) begin
                dv_reg[j] <= dv_next[j];
            end
        end
        for (int j = 0; j < 4; j++) begin
            if (rdy[6+j]) begin
                sq_reg[j] <= sq_next[j];
            end
        end
    end

    // stage 10: light factor
    always_comb begin
        logic [16:0] s;
        logic [33:0] term;
        f_next.ctl = sq_reg[3].ctl;
        f_next.bo  = sq_reg[3].bo;
        for (int i = 0; i < 4; i++) begin
            s    = sq_reg[3].full[i] ? vcos_pkg::ONE_Q16 : sq_reg[3].res[i][16:0];
            term = 34'(span_reg) * 34'(s) + 34'd32768;
            if (sq_reg[3].ctl.sloped) begin
                f_next.f[i] = {1'b0, floor_reg} + {1'b0, term[31:16]};
            end else if (sq_reg[3].ctl.ledge) begin
                f_next.f[i] = {1'b0, lfac_reg};
            end else begin
                f_next.f[i] = vcos_pkg::ONE_Q16;
            end
        end
    end

    // stage 11: brightness times occlusion times factor
    always_comb begin
        p_next.ctl = f_reg.ctl;
        for (int i = 0; i < 4; i++) begin
            p_next.p[i] = f_reg.bo[i] * f_reg.f[i];
        end
    end

    // stage 12: scale by 1/(255*2^16), round half up, saturate, if enabled
    always_comb begin
        logic [18:0] y;
        for (int i = 0; i < 4; i++) begin
            y = {1'b0, p_reg.p[i][32:15]} + 19'd255;
            if (!p_reg.ctl.en) begin
                out_next[i] = p_reg.ctl.bright;
            end else if (y >= vcos_pkg::SAT_LIMIT) begin
                out_next[i] = 8'd255;
            end else begin
                out_next[i] = vcos_pkg::div510(y[16:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[10]) begin
            f_reg <= f_next;
        end
        if (rdy[11]) begin
            p_reg <= p_next;
        end
        if (rdy[12]) begin
            out_reg <= out_next;
        end
    end

    // the divider remainder stays below the range on lanes it serves
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |->
            (dv_reg[4].full[0] || dv_reg[4].rem[0] < dv_reg[4].rng) &&
            (dv_reg[4].full[1] || dv_reg[4].rem[1] < dv_reg[4].rng) &&
            (dv_reg[4].full[2] || dv_reg[4].rem[2] < dv_reg[4].rng) &&
            (dv_reg[4].full[3] || dv_reg[4].rem[3] < dv_reg[4].rng))
        else $error("normalize remainder not below range");

    // a root of a value below 2^32 fits in 16 bits
    a_sqrt_width: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[9] |->
            sq_reg[3].res[0][31:16] == 16'd0 && sq_reg[3].res[1][31:16] == 16'd0 &&
            sq_reg[3].res[2][31:16] == 16'd0 && sq_reg[3].res[3][31:16] == 16'd0)
        else $error("square root result too wide");

    // an empty pipeline always takes a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg == '0 |-> s_tready)
        else $error("empty pipeline refuses input");

endmodule

/* tb/sv/tb_vertex_contact_occlusion_shader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_contact_occlusion_shader
// Self-checking bench for the contact occlusion shader: faces are sent over
// the input stream, a behavioral shading model predicts the four brightnesses
// of each face, and every output word is compared in order against it.
// ----------------------------------------------------------------------------
module tb_vertex_contact_occlusion_shader;

    localparam int LATENCY    = 12;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] z[4];
        logic signed [15:0] mn;
        logic signed [15:0] mx;
        logic [7:0]         occ[4];
        logic [7:0]         bright;
        logic               en;
    } face_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    logic [15:0] floor_q;
    logic [15:0] span_q;
    logic [15:0] ledge_frac_q;
    logic [15:0] ledge_fac_q;
    logic [14:0] eps_q;

    logic [31:0] shade_queue[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          failed;
    int          idle_cycles;

    vertex_contact_occlusion_shader u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned root_q16(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] shade_face(input face_t fc);
        logic [31:0] res;
        int fmin, fmax, fspan, rng, eps, h;
        longint unsigned f, n, s, q;
        longint lhs, rhs;
        fmin = fc.z[0];
        fmax = fc.z[0];
        for (int i = 1; i < 4; i++) begin
            if (fc.z[i] < fmin) fmin = fc.z[i];
            if (fc.z[i] > fmax) fmax = fc.z[i];
        end
        fspan = fmax - fmin;
        rng   = int'(fc.mx) - int'(fc.mn);
        eps   = int'(eps_q);
        for (int i = 0; i < 4; i++) begin
            if (!fc.en) begin
                res[8*i +: 8] = fc.bright;
                continue;
            end
            f = 65536;
            if (fspan > eps) begin
                if (rng > eps) begin
                    h = int'(fc.z[i]) - int'(fc.mn);
                    if (h <= 0) n = 0;
                    else if (h >= rng) n = 65536;
                    else n = (longint'(h) << 16) / longint'(rng);
                end else begin
                    n = 65536;
                end
                s = root_q16(n << 16);
                f = longint'(floor_q) + ((longint'(span_q) * s + 32768) >> 16);
            end else begin
                lhs = longint'(fmax) * 65536;
                rhs = longint'(fc.mx) * longint'(ledge_frac_q);
                if (lhs < rhs) f = ledge_fac_q;
            end
            q = (longint'(fc.bright) * f * fc.occ[i] * 2 + 255 * 65536) / (2 * 255 * 65536);
            if (q > 255) q = 255;
            res[8*i +: 8] = q[7:0];
        end
        return res;
    endfunction

    // random idling on the receive side
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shade_queue.size() == 0) begin
                $error("unexpected output word %h", m_tdata);
                failed = 1'b1;
            end else begin
                want = shade_queue.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[8*i +: 8] !== want[8*i +: 8]) begin
                        $error("brightness%0d expected %0d actual %0d", i,
                               want[8*i +: 8], m_tdata[8*i +: 8]);
                        failed = 1'b1;
                    end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // leave s_tvalid high after the handshake; the next call or the caller drops it
    task automatic send_face(input face_t fc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fc.en;
        s_tdata  <= {fc.bright, fc.occ[3], fc.occ[2], fc.occ[1], fc.occ[0],
                     fc.mx, fc.mn, fc.z[3], fc.z[2], fc.z[1], fc.z[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        shade_queue.push_back(shade_face(fc));
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (shade_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            vcos_pkg::CFG_CONTACT_FLOOR:  floor_q      = val;
            vcos_pkg::CFG_CONTACT_SPAN:   span_q       = val;
            vcos_pkg::CFG_LEDGE_FRACTION: ledge_frac_q = val;
            vcos_pkg::CFG_LEDGE_FACTOR:   ledge_fac_q  = val;
            vcos_pkg::CFG_FLAT_EPSILON:   eps_q        = val[14:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [15:0] fl, input logic [15:0] sp,
                             input logic [15:0] lf, input logic [15:0] lk,
                             input logic [15:0] ep);
        write_reg(vcos_pkg::CFG_CONTACT_FLOOR, fl);
        write_reg(vcos_pkg::CFG_CONTACT_SPAN, sp);
        write_reg(vcos_pkg::CFG_LEDGE_FRACTION, lf);
        write_reg(vcos_pkg::CFG_LEDGE_FACTOR, lk);
        write_reg(vcos_pkg::CFG_FLAT_EPSILON, ep);
        cfg_valid <= 1'b0;
    endtask

    function automatic face_t rand_face(input int style);
        face_t fc;
        int base, spread;
        fc.mn = 16'($urandom);
        fc.mx = 16'($urandom);
        base  = int'($urandom_range(65535)) - 32768;
        spread = (style == 0) ? 32 : 65535;
        if (style == 0 || style == 1) begin
            // realistic model: ordered bounds, vertices near a base height
            fc.mn = 16'(-int'($urandom_range(8000)));
            fc.mx = 16'($urandom_range(12000));
            base  = int'($urandom_range(int'(fc.mx) - int'(fc.mn))) + int'(fc.mn);
            spread = (style == 0) ? 24 : 3000;
        end
        for (int i = 0; i < 4; i++) begin
            if (style >= 2) fc.z[i] = 16'($urandom);
            else fc.z[i] = 16'(base + int'($urandom_range(spread)) - spread / 2);
            fc.occ[i] = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom);
        end
        fc.bright = ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom);
        fc.en     = ($urandom_range(7) != 0);
        return fc;
    endfunction

    task automatic test_directed();
        face_t fc;
        for (int k = 0; k < 20; k++) begin
            fc.mn = -16'sd256; fc.mx = 16'sd2560;
            fc.z[0] = -16'sd512; fc.z[1] = 16'sd0; fc.z[2] = 16'sd1280;
            fc.z[3] = 16'sd4000;
            for (int i = 0; i < 4; i++) fc.occ[i] = 8'd255;
            fc.bright = 8'd255; fc.en = 1'b1;
            case (k)
                1: fc.en = 1'b0;
                2: begin fc.bright = 8'd0; fc.en = 1'b0; end
                3: for (int i = 0; i < 4; i++) fc.z[i] = 16'sd100;       // low ledge
                4: for (int i = 0; i < 4; i++) fc.z[i] = 16'sd2500;      // high flat
                5: begin fc.mx = -16'sd256; end                            // degenerate range
                6: begin fc.mn = 16'sd3000; fc.mx = -16'sd3000; end      // inverted bounds
                7: for (int i = 0; i < 4; i++) fc.occ[i] = 8'd0;
                8: begin fc.z[0] = 16'sh8000; fc.z[3] = 16'sh7FFF; end
                9: begin fc.mn = 16'sh8000; fc.mx = 16'sh7FFF; end
                10: begin fc.z[1] = 16'(fc.z[0] + 13); fc.z[2] = fc.z[0];
                          fc.z[3] = fc.z[0]; end                           // span at epsilon
                11: begin fc.z[1] = 16'(fc.z[0] + 14); fc.z[2] = fc.z[0];
                          fc.z[3] = fc.z[0]; end
                12: begin fc.mx = 16'(fc.mn + 13); end
                13: begin fc.mx = 16'(fc.mn + 14); end
                14: begin for (int i = 0; i < 4; i++) fc.z[i] = 16'sh8000;
                          fc.mx = 16'sh7FFF; end
                15: begin fc.occ[0] = 8'd1; fc.occ[1] = 8'd128; fc.bright = 8'd1; end
                16: begin for (int i = 0; i < 4; i++) fc.z[i] = -16'sd700;
                          fc.mx = -16'sd100; end                           // flat, negative top
                17: begin fc.bright = 8'hAA; fc.occ[2] = 8'h55; end
                18: begin fc.bright = 8'h55; fc.occ[3] = 8'hAA; fc.en = 1'b0; end
                default: ;
            endcase
            send_face(fc);
        end
    endtask

    task automatic test_random(input int count, input int sidle, input int rstall);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int k = 0; k < count; k++) begin
            send_face(rand_face($urandom_range(9) < 4 ? 0 : ($urandom_range(3) == 0 ? 2 : 1)));
            // hold the sender until everything has come out
            if (k == count / 2) begin
                s_tvalid <= 1'b0;
                while (shade_queue.size() != 0) @(posedge aclk);
            end
        end
        drain_pipe();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failed    = 1'b0;
        idle_cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        floor_q      = vcos_pkg::RST_CONTACT_FLOOR;
        span_q       = vcos_pkg::RST_CONTACT_SPAN;
        ledge_frac_q = vcos_pkg::RST_LEDGE_FRACTION;
        ledge_fac_q  = vcos_pkg::RST_LEDGE_FACTOR;
        eps_q        = vcos_pkg::RST_FLAT_EPSILON;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        drain_pipe();
        test_random(150, 0, 0);
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        test_directed();
        test_random(150, 60, 0);
        load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        test_directed();
        test_random(150, 0, 60);
        load_regs(16'd30000, 16'd40000, 16'd32768, 16'd4464, 16'd2);
        test_random(150, 10, 10);
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(64)));
        test_random(100, 0, 0);
        load_regs(vcos_pkg::RST_CONTACT_FLOOR, vcos_pkg::RST_CONTACT_SPAN,
                  vcos_pkg::RST_LEDGE_FRACTION, vcos_pkg::RST_LEDGE_FACTOR,
                  {1'b0, vcos_pkg::RST_FLAT_EPSILON});
        test_random(100, 30, 30);

        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
